>>> rtl/core/ecc_pkg.sv
// Constants, reciprocal factors and the month offset table of the epoch calendar converter.
// Depends on nothing; imported by the converter top level.
`default_nettype none

package ecc_pkg;

	typedef struct packed {
		logic vld;
		logic fn;
		logic err;
	} ctl_t;

	localparam logic [13:0] YEAR_MIN        = 14'd1583;
	localparam logic [13:0] YEAR_MAX        = 14'd9999;
	localparam logic [13:0] TWO_DIGIT_LIMIT = 14'd100;
	localparam logic [13:0] CENTURY_PIVOT   = 14'd50;
	localparam logic [13:0] CENTURY_20      = 14'd2000;
	localparam logic [13:0] CENTURY_19      = 14'd1900;
	localparam logic [13:0] YEARS_PER_ERA   = 14'd400;
	localparam logic [3:0]  MONTHS          = 4'd12;

	// 1583-01-01 00:00:00.000 and 9999-12-31 23:59:59.999
	localparam logic signed [48:0] EPOCH_MS_LO = -49'sd12212553600000;
	localparam logic signed [48:0] EPOCH_MS_HI = 49'sd253402300799999;

	localparam logic signed [27:0] MS_PER_DAY    = 28'sd86400000;
	localparam logic [26:0]        MS_PER_HOUR   = 27'd3600000;
	localparam logic [26:0]        MS_PER_MINUTE = 27'd60000;

	// ms per day = 1024 * DAY_DIV
	localparam logic [16:0] DAY_DIV   = 17'd84375;
	localparam logic [17:0] DAY_DIV2  = 18'd168750;
	localparam logic [21:0] DAY_RECIP = 22'(((64'd1 << 38)) / 64'd84375);

	// days from 0000-03-01 to 1583-01-01, and to 1970-01-01 plus one
	localparam logic [21:0]        CIVIL_OFS      = 22'd578119;
	localparam logic signed [23:0] CIVIL_TO_EPOCH = 24'sd719469;

	localparam logic [21:0] ERA_DAYS      = 22'd146097;
	localparam logic [17:0] DOE_LAST      = 18'd146096;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	localparam logic [10:0] MINS_PER_HOUR = 11'd60;

	// ceil(2^k / D), exact over the operand width used with each
	localparam logic [14:0] MAG_100   = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
	localparam logic [11:0] MAG_60    = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
	localparam logic [11:0] MAG_153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
	localparam logic [22:0] MAG_1875  = 23'(((64'd1 << 33) + 64'd1874) / 64'd1875);
	localparam logic [22:0] MAG_ERA   = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [18:0] MAG_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
	localparam logic [18:0] MAG_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
	localparam logic [18:0] MAG_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);

	// first day of a March-based month within the year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/epoch_calendar_converter_top.sv
// Epoch calendar converter: eleven-stage pipeline between calendar date-time and epoch ms.
// Depends on ecc_pkg for constants, reciprocal factors and the month table.
//
//   channel   signals                                  handshake
//   request   start, busy, func, *_in                  taken when start & !busy
//   result    done, epoch_ms_out, *_out, range_error   one cycle, done high
//
// One request enters per cycle; its result leaves the last stage register after the
// chain of constant divisions (day split, era, year of era, month) spread over the stages.
// busy stays low: the pipeline never stalls, as the receiver cannot hold results off.
// Reset clears only the control bits (vld, fn, err); data registers load every cycle.
`default_nettype none

module epoch_calendar_converter_top import ecc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [13:0]        year_in,
	input  logic [3:0]         month_in,
	input  logic [4:0]         day_in,
	input  logic [4:0]         hour_in,
	input  logic [5:0]         minute_in,
	input  logic [15:0]        millis_in,
	input  logic signed [48:0] epoch_ms_in,
	output logic               done,
	output logic signed [48:0] epoch_ms_out,
	output logic [13:0]        year_out,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out,
	output logic [4:0]         hour_out,
	output logic [5:0]         minute_out,
	output logic [15:0]        millis_out,
	output logic               range_error
);

	ctl_t ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	ctl_t ctl_s7, ctl_s8, ctl_s9, ctl_s10, ctl_s11;

	// Never hold off a request.
	assign busy = 1'b0;

	// ---------------- stage 1: year mapping, range checks, offset ----------------
	logic [13:0] ymap;
	logic        err_date, err_ms;
	logic [48:0] u_full;

	always_comb begin
		ymap = year_in;
		if (year_in < TWO_DIGIT_LIMIT) begin
			ymap = year_in + ((year_in < CENTURY_PIVOT) ? CENTURY_20 : CENTURY_19);
		end
		err_date = (ymap < YEAR_MIN) || (ymap > YEAR_MAX) ||
			(month_in == 4'd0) || (month_in > MONTHS);
		err_ms = (epoch_ms_in < EPOCH_MS_LO) || (epoch_ms_in > EPOCH_MS_HI);
		// Shift valid times to count from 1583-01-01; floor division then needs no sign fix.
		u_full = epoch_ms_in - EPOCH_MS_LO;
		ctl_in.vld = start;
		ctl_in.fn  = func;
		ctl_in.err = func ? err_ms : err_date;
	end

	// Advance control through the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			ctl_s9  <= '0;
			ctl_s10 <= '0;
			ctl_s11 <= '0;
		end else begin
			ctl_s1  <= ctl_in;
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_s4  <= ctl_s3;
			ctl_s5  <= ctl_s4;
			ctl_s6  <= ctl_s5;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			ctl_s9  <= ctl_s8;
			ctl_s10 <= ctl_s9;
			ctl_s11 <= ctl_s10;
		end
	end

	logic [13:0] yp_s1;
	logic [3:0]  mp0_s1;
	logic [4:0]  dd_s1, hh_s1;
	logic [5:0]  mi_s1;
	logic [15:0] ms_s1;
	logic [47:0] u_s1;

	always_ff @(posedge clk) begin
		// Count the year from March so the leap day ends it.
		yp_s1  <= ymap - ((month_in <= 4'd2) ? 14'd1 : 14'd0);
		mp0_s1 <= (month_in > 4'd2) ? month_in - 4'd3 : month_in + 4'd9;
		dd_s1  <= day_in;
		hh_s1  <= hour_in;
		mi_s1  <= minute_in;
		ms_s1  <= millis_in;
		u_s1   <= u_full[47:0];
	end

	// ---------------- stage 2: year / 100; day quotient estimate ----------------
	logic [28:0] p_q100;
	logic [43:0] p_day;

	assign p_q100 = 29'(yp_s1) * 29'(MAG_100);
	// Estimate from the top bits of (ms >> 10); at most two short.
	assign p_day  = 44'(u_s1[47:26]) * 44'(DAY_RECIP);

	logic [13:0] yp_s2;
	logic [6:0]  q100_s2;
	logic [3:0]  mp0_s2;
	logic [4:0]  dd_s2, hh_s2;
	logic [5:0]  mi_s2;
	logic [15:0] ms_s2;
	logic [37:0] x_s2;
	logic [9:0]  lo_s2;
	logic [21:0] q0_s2;

	always_ff @(posedge clk) begin
		yp_s2   <= yp_s1;
		q100_s2 <= p_q100[27:21];
		mp0_s2  <= mp0_s1;
		dd_s2   <= dd_s1;
		hh_s2   <= hh_s1;
		mi_s2   <= mi_s1;
		ms_s2   <= ms_s1;
		x_s2    <= u_s1[47:10];
		lo_s2   <= u_s1[9:0];
		q0_s2   <= p_day[43:22];
	end

	// ---------------- stage 3: day number; trial remainder ----------------
	logic [22:0]        day_pos;
	logic signed [23:0] days_full;
	logic [38:0]        r_full;

	always_comb begin
		day_pos = 23'(yp_s2) * 23'(DAYS_PER_YEAR) + 23'(yp_s2[13:2]) - 23'(q100_s2)
			+ 23'(q100_s2[6:2]) + 23'(month_start(mp0_s2)) + 23'(dd_s2);
		days_full = $signed({1'b0, day_pos}) - CIVIL_TO_EPOCH;
		r_full    = 39'(x_s2) - 39'(q0_s2) * 39'(DAY_DIV);
	end

	logic signed [23:0] days_s3;
	logic [4:0]         hh_s3;
	logic [5:0]         mi_s3;
	logic [15:0]        ms_s3;
	logic [17:0]        r_s3;
	logic [21:0]        q0_s3;
	logic [9:0]         lo_s3;

	always_ff @(posedge clk) begin
		days_s3 <= days_full;
		hh_s3   <= hh_s2;
		mi_s3   <= mi_s2;
		ms_s3   <= ms_s2;
		r_s3    <= r_full[17:0];
		q0_s3   <= q0_s2;
		lo_s3   <= lo_s2;
	end

	// ---------------- stage 4: day to ms; fix the day quotient ----------------
	logic signed [51:0] p_dayms;
	logic [26:0]        hm_full;
	logic [21:0]        q_fix;
	logic [16:0]        r_fix;

	always_comb begin
		p_dayms = 52'(days_s3) * 52'(MS_PER_DAY);
		hm_full = 27'(hh_s3) * MS_PER_HOUR + 27'(mi_s3) * MS_PER_MINUTE + 27'(ms_s3);
		// Drop the estimate error: add back up to two divisors.
		if (r_s3 >= DAY_DIV2) begin
			q_fix = q0_s3 + 22'd2;
			r_fix = 17'(r_s3 - DAY_DIV2);
		end else if (r_s3 >= 18'(DAY_DIV)) begin
			q_fix = q0_s3 + 22'd1;
			r_fix = 17'(r_s3 - 18'(DAY_DIV));
		end else begin
			q_fix = q0_s3;
			r_fix = r_s3[16:0];
		end
	end

	logic [48:0] dayms_s4;
	logic [26:0] hm_s4;
	logic [21:0] z_s4;
	logic [26:0] rem_s4;

	always_ff @(posedge clk) begin
		dayms_s4 <= p_dayms[48:0];
		hm_s4    <= hm_full;
		z_s4     <= q_fix + CIVIL_OFS;
		rem_s4   <= {r_fix, lo_s3};
	end

	// ---------------- stage 5: epoch sum; era and minute of day ----------------
	logic [44:0] p_era, p_tm;

	assign p_era = 45'(z_s4) * 45'(MAG_ERA);
	assign p_tm  = 45'(rem_s4[26:5]) * 45'(MAG_1875);

	logic [48:0] tot_s5;
	logic [4:0]  era_s5;
	logic [10:0] tm_s5;
	logic [21:0] z_s5;
	logic [26:0] rem_s5;

	always_ff @(posedge clk) begin
		tot_s5 <= dayms_s4 + 49'(hm_s4);
		era_s5 <= p_era[44:40];
		tm_s5  <= p_tm[43:33];
		z_s5   <= z_s4;
		rem_s5 <= rem_s4;
	end

	// ---------------- stage 6: day of era, hour, millis ----------------
	logic [21:0] doe_full;
	logic [26:0] msm_full;
	logic [22:0] p_hour;

	assign doe_full = z_s5 - 22'(era_s5) * ERA_DAYS;
	assign msm_full = rem_s5 - 27'(tm_s5) * MS_PER_MINUTE;
	assign p_hour   = 23'(tm_s5) * 23'(MAG_60);

	logic [48:0] tot_s6;
	logic [4:0]  era_s6, hour_s6;
	logic [10:0] tm_s6;
	logic [17:0] doe_s6;
	logic [15:0] msm_s6;

	always_ff @(posedge clk) begin
		tot_s6  <= tot_s5;
		era_s6  <= era_s5;
		tm_s6   <= tm_s5;
		doe_s6  <= doe_full[17:0];
		msm_s6  <= msm_full[15:0];
		hour_s6 <= p_hour[21:17];
	end

	// ---------------- stage 7: leap correction inside the era; minute ----------------
	logic [36:0] p_a, p_b;
	logic [17:0] t_full;
	logic [10:0] min_full;

	always_comb begin
		p_a = 37'(doe_s6) * 37'(MAG_1460);
		p_b = 37'(doe_s6) * 37'(MAG_36524);
		t_full = doe_s6 - 18'(p_a[35:29]) + 18'(p_b[36:34])
			- ((doe_s6 == DOE_LAST) ? 18'd1 : 18'd0);
		min_full = tm_s6 - 11'(hour_s6) * MINS_PER_HOUR;
	end

	logic [48:0] tot_s7;
	logic [4:0]  era_s7, hour_s7;
	logic [5:0]  min_s7;
	logic [17:0] doe_s7, t_s7;
	logic [15:0] msm_s7;

	always_ff @(posedge clk) begin
		tot_s7  <= tot_s6;
		era_s7  <= era_s6;
		hour_s7 <= hour_s6;
		min_s7  <= min_full[5:0];
		doe_s7  <= doe_s6;
		t_s7    <= t_full;
		msm_s7  <= msm_s6;
	end

	// ---------------- stage 8: year of era ----------------
	logic [36:0] p_yoe;

	assign p_yoe = 37'(t_s7) * 37'(MAG_365);

	logic [48:0] tot_s8;
	logic [4:0]  era_s8, hour_s8;
	logic [5:0]  min_s8;
	logic [17:0] doe_s8;
	logic [15:0] msm_s8;
	logic [8:0]  yoe_s8;

	always_ff @(posedge clk) begin
		tot_s8  <= tot_s7;
		era_s8  <= era_s7;
		hour_s8 <= hour_s7;
		min_s8  <= min_s7;
		doe_s8  <= doe_s7;
		msm_s8  <= msm_s7;
		yoe_s8  <= p_yoe[35:27];
	end

	// ---------------- stage 9: day of year ----------------
	logic [23:0] p_yq;
	logic [17:0] yd_full, doy_full;

	always_comb begin
		p_yq     = 24'(yoe_s8) * 24'(MAG_100);
		yd_full  = 18'(yoe_s8) * 18'(DAYS_PER_YEAR) + 18'(yoe_s8[8:2]) - 18'(p_yq[23:21]);
		doy_full = doe_s8 - yd_full;
	end

	logic [48:0] tot_s9;
	logic [4:0]  era_s9, hour_s9;
	logic [5:0]  min_s9;
	logic [15:0] msm_s9;
	logic [8:0]  yoe_s9, doy_s9;

	always_ff @(posedge clk) begin
		tot_s9  <= tot_s8;
		era_s9  <= era_s8;
		hour_s9 <= hour_s8;
		min_s9  <= min_s8;
		msm_s9  <= msm_s8;
		yoe_s9  <= yoe_s8;
		doy_s9  <= doy_full[8:0];
	end

	// ---------------- stage 10: March-based month ----------------
	logic [10:0] mq;
	logic [22:0] p_mp;

	assign mq   = 11'(doy_s9) * 11'(3'd5) + 11'd2;
	assign p_mp = 23'(mq) * 23'(MAG_153);

	logic [48:0] tot_s10;
	logic [4:0]  era_s10, hour_s10;
	logic [5:0]  min_s10;
	logic [15:0] msm_s10;
	logic [8:0]  yoe_s10, doy_s10;
	logic [3:0]  mp_s10;

	always_ff @(posedge clk) begin
		tot_s10  <= tot_s9;
		era_s10  <= era_s9;
		hour_s10 <= hour_s9;
		min_s10  <= min_s9;
		msm_s10  <= msm_s9;
		yoe_s10  <= yoe_s9;
		doy_s10  <= doy_s9;
		mp_s10   <= p_mp[22:19];
	end

	// ---------------- stage 11: calendar fields, zero unused, register out ----------------
	logic [8:0]  dom_full;
	logic [3:0]  mon;
	logic [13:0] yr;

	always_comb begin
		dom_full = doy_s10 - month_start(mp_s10) + 9'd1;
		mon      = (mp_s10 < 4'd10) ? mp_s10 + 4'd3 : mp_s10 - 4'd9;
		// Move January and February back into the civil year.
		yr = 14'(yoe_s10) + 14'(era_s10) * YEARS_PER_ERA
			+ ((mon <= 4'd2) ? 14'd1 : 14'd0);
	end

	logic [48:0] epoch_s11;
	logic [13:0] year_s11;
	logic [3:0]  month_s11;
	logic [4:0]  day_s11, hour_s11;
	logic [5:0]  minute_s11;
	logic [15:0] millis_s11;

	always_ff @(posedge clk) begin
		if (ctl_s10.err) begin
			epoch_s11  <= '0;
			year_s11   <= '0;
			month_s11  <= '0;
			day_s11    <= '0;
			hour_s11   <= '0;
			minute_s11 <= '0;
			millis_s11 <= '0;
		end else if (ctl_s10.fn) begin
			epoch_s11  <= '0;
			year_s11   <= yr;
			month_s11  <= mon;
			day_s11    <= dom_full[4:0];
			hour_s11   <= hour_s10;
			minute_s11 <= min_s10;
			millis_s11 <= msm_s10;
		end else begin
			epoch_s11  <= tot_s10;
			year_s11   <= '0;
			month_s11  <= '0;
			day_s11    <= '0;
			hour_s11   <= '0;
			minute_s11 <= '0;
			millis_s11 <= '0;
		end
	end

	// Strobe each result for its single cycle.
	assign done         = ctl_s11.vld;
	assign range_error  = ctl_s11.err;
	assign epoch_ms_out = $signed(epoch_s11);
	assign year_out     = year_s11;
	assign month_out    = month_s11;
	assign day_out      = day_s11;
	assign hour_out     = hour_s11;
	assign minute_out   = minute_s11;
	assign millis_out   = millis_s11;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for epoch_calendar_converter_top: date-time to epoch ms and back.
// Depends on the converter RTL and ecc_pkg; random bursts drive requests, a scoreboard
// compares every result with a predictor kept in this file.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Conversion direction as carried by the func port
	typedef enum logic {
		TO_EPOCH    = 1'b0,
		TO_CALENDAR = 1'b1
	} conv_dir_e;

	typedef struct {
		conv_dir_e          dir;
		logic [13:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [15:0]        millis;
		logic signed [48:0] epoch_ms;
		bit                 drain_before;
	} calendar_req_t;

	typedef struct {
		logic signed [48:0] epoch_ms;
		logic [13:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [15:0]        millis;
		logic               range_err;
	} calendar_res_t;

	localparam longint MS_DAY      = 64'sd86400000;
	localparam longint MS_HOUR     = 64'sd3600000;
	localparam longint MS_MINUTE   = 64'sd60000;
	localparam int     FIRST_YEAR  = 1583;
	localparam int     LAST_YEAR   = 9999;
	// 1583-01-01 00:00:00.000 and 9999-12-31 23:59:59.999 in epoch ms
	localparam longint EARLIEST_MS = -64'sd12212553600000;
	localparam longint LATEST_MS   = 64'sd253402300799999;
	localparam int     PIPE_DEPTH  = 11;
	localparam int     RANDOM_REQS = 2000;
	localparam int     IDLE_LIMIT  = 2000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               func = TO_EPOCH;
	logic [13:0]        year_in = '0;
	logic [3:0]         month_in = '0;
	logic [4:0]         day_in = '0;
	logic [4:0]         hour_in = '0;
	logic [5:0]         minute_in = '0;
	logic [15:0]        millis_in = '0;
	logic signed [48:0] epoch_ms_in = '0;
	logic               done;
	logic signed [48:0] epoch_ms_out;
	logic [13:0]        year_out;
	logic [3:0]         month_out;
	logic [4:0]         day_out;
	logic [4:0]         hour_out;
	logic [5:0]         minute_out;
	logic [15:0]        millis_out;
	logic               range_error;

	calendar_req_t pending_reqs[$];
	calendar_res_t expected_results[$];
	int            mismatches = 0;

	epoch_calendar_converter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.year_in      (year_in),
		.month_in     (month_in),
		.day_in       (day_in),
		.hour_in      (hour_in),
		.minute_in    (minute_in),
		.millis_in    (millis_in),
		.epoch_ms_in  (epoch_ms_in),
		.done         (done),
		.epoch_ms_out (epoch_ms_out),
		.year_out     (year_out),
		.month_out    (month_out),
		.day_out      (day_out),
		.hour_out     (hour_out),
		.minute_out   (minute_out),
		.millis_out   (millis_out),
		.range_error  (range_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// Days from 1970-01-01 to a proleptic Gregorian date, counted from a March-based year
	function automatic longint days_from_civil(longint y, longint m, longint d);
		longint era, yoe, doy, doe;
		if (m <= 2)
			y = y - 1;
		era = y / 400;
		yoe = y - era * 400;
		doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
		doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era * 146097 + doe - 719468;
	endfunction

	// Inverse of days_from_civil; division truncates toward zero, so adjust the era by hand
	function automatic void civil_from_days(input longint days, output longint y,
			output longint m, output longint d);
		longint z, era, doe, yoe, doy, mp;
		z = days + 719468;
		era = (z >= 0 ? z : z - 146096) / 146097;
		doe = z - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		d = doy - (153 * mp + 2) / 5 + 1;
		m = mp < 10 ? mp + 3 : mp - 9;
		y = yoe + era * 400 + (m <= 2 ? 1 : 0);
	endfunction

	function automatic calendar_res_t convert_calendar(calendar_req_t r);
		calendar_res_t res;
		longint y, m, d, total, v, days, rem;
		res = '{default: '0};
		if (r.dir == TO_EPOCH) begin
			y = r.year;
			m = r.month;
			// map two-digit years: below 50 into 20xx, the rest into 19xx
			if (y < 100)
				y = y + ((y < 50) ? 2000 : 1900);
			if (y < FIRST_YEAR || y > LAST_YEAR || m < 1 || m > 12) begin
				res.range_err = 1'b1;
			end else begin
				total = days_from_civil(y, m, longint'(r.day)) * MS_DAY
					+ longint'(r.hour) * MS_HOUR + longint'(r.minute) * MS_MINUTE
					+ longint'(r.millis);
				res.epoch_ms = total[48:0];
			end
		end else begin
			v = longint'(r.epoch_ms);
			// floor division keeps time of day non-negative before 1970
			days = v / MS_DAY;
			rem = v - days * MS_DAY;
			if (rem < 0) begin
				rem = rem + MS_DAY;
				days = days - 1;
			end
			civil_from_days(days, y, m, d);
			if (y < FIRST_YEAR || y > LAST_YEAR) begin
				res.range_err = 1'b1;
			end else begin
				res.year = y[13:0];
				res.month = m[3:0];
				res.day = d[4:0];
				res.hour = 5'(rem / MS_HOUR);
				rem = rem % MS_HOUR;
				res.minute = 6'(rem / MS_MINUTE);
				res.millis = 16'(rem % MS_MINUTE);
			end
		end
		return res;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic logic signed [48:0] any_epoch_ms();
		bit [63:0] r;
		r = {$urandom, $urandom};
		return r[48:0];
	endfunction

	function automatic longint epoch_between(longint lo, longint hi);
		bit [63:0] r;
		r = {$urandom, $urandom};
		return lo + longint'(r[62:0] % (hi - lo + 1));
	endfunction

	// Queue a date-time request; the unused epoch field carries noise
	task automatic add_date(int y, int m, int d, int h, int mi, int ms);
		calendar_req_t r;
		r.dir = TO_EPOCH;
		r.year = y[13:0];
		r.month = m[3:0];
		r.day = d[4:0];
		r.hour = h[4:0];
		r.minute = mi[5:0];
		r.millis = ms[15:0];
		r.epoch_ms = any_epoch_ms();
		r.drain_before = 1'b0;
		pending_reqs.push_back(r);
	endtask

	// Queue an epoch request; the unused calendar fields carry noise
	task automatic add_epoch(longint ms);
		calendar_req_t r;
		r.dir = TO_CALENDAR;
		r.year = 14'($urandom);
		r.month = 4'($urandom);
		r.day = 5'($urandom);
		r.hour = 5'($urandom);
		r.minute = 6'($urandom);
		r.millis = 16'($urandom);
		r.epoch_ms = ms[48:0];
		r.drain_before = 1'b0;
		pending_reqs.push_back(r);
	endtask

	// ---------------------------------------------------------------- driver

	calendar_req_t on_bus;
	int            burst_left = 0;
	int            gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			func <= TO_EPOCH;
			year_in <= '0;
			month_in <= '0;
			day_in <= '0;
			hour_in <= '0;
			minute_in <= '0;
			millis_in <= '0;
			epoch_ms_in <= '0;
		end else begin
			// record the expectation for a request taken at this edge
			if (start && !busy)
				expected_results.push_back(convert_calendar(on_bus));
			// hold a request that has not been taken yet
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_reqs.size() == 0) begin
					start <= 1'b0;
				end else if (pending_reqs[0].drain_before && expected_results.size() != 0) begin
					// hold off until the pipeline has emptied
					start <= 1'b0;
				end else begin
					on_bus = pending_reqs.pop_front();
					start <= 1'b1;
					func <= on_bus.dir;
					year_in <= on_bus.year;
					month_in <= on_bus.month;
					day_in <= on_bus.day;
					hour_in <= on_bus.hour;
					minute_in <= on_bus.minute;
					millis_in <= on_bus.millis;
					epoch_ms_in <= on_bus.epoch_ms;
					burst_left--;
					if (burst_left <= 0) begin
						// now and then a long burst with no gaps at all
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic void check_field(string name, longint exp_val, longint act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	calendar_res_t oldest;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result strobe with no request outstanding");
				mismatches++;
			end else begin
				oldest = expected_results.pop_front();
				check_field("epoch_ms_out", longint'(oldest.epoch_ms), longint'(epoch_ms_out));
				check_field("year_out", longint'(oldest.year), longint'(year_out));
				check_field("month_out", longint'(oldest.month), longint'(month_out));
				check_field("day_out", longint'(oldest.day), longint'(day_out));
				check_field("hour_out", longint'(oldest.hour), longint'(hour_out));
				check_field("minute_out", longint'(oldest.minute), longint'(minute_out));
				check_field("millis_out", longint'(oldest.millis), longint'(millis_out));
				check_field("range_error", longint'(oldest.range_err), longint'(range_error));
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int     n_directed;
		int     y, m, d, h, mi, ms;
		longint t;

		// directed: two-digit year pivot, year bounds, bad months, field overflow
		add_date(0, 1, 1, 0, 0, 0);
		add_date(49, 12, 31, 23, 59, 59999);
		add_date(50, 1, 1, 0, 0, 0);
		add_date(99, 6, 15, 12, 30, 30000);
		add_date(100, 1, 1, 0, 0, 0);
		add_date(1582, 12, 31, 23, 59, 59999);
		add_date(1583, 1, 1, 0, 0, 0);
		add_date(9999, 12, 31, 23, 59, 59999);
		add_date(10000, 1, 1, 0, 0, 0);
		add_date(16383, 15, 31, 31, 63, 65535);
		add_date(1970, 0, 1, 0, 0, 0);
		add_date(1970, 13, 1, 0, 0, 0);
		add_date(2000, 15, 1, 0, 0, 0);
		// day 0 falls back a month; overlong fields run into the next unit
		add_date(1970, 3, 0, 0, 0, 0);
		add_date(2000, 2, 29, 0, 0, 0);
		add_date(1900, 2, 29, 31, 63, 65535);
		add_date(1969, 12, 31, 23, 59, 59999);
		// epoch side: day boundary around zero, year bounds, full signed range
		add_epoch(0);
		add_epoch(-1);
		add_epoch(-MS_DAY);
		add_epoch(-MS_DAY - 1);
		add_epoch(EARLIEST_MS);
		add_epoch(EARLIEST_MS - 1);
		add_epoch(LATEST_MS);
		add_epoch(LATEST_MS + 1);
		add_epoch(-(64'sd1 <<< 48));
		add_epoch((64'sd1 <<< 48) - 1);
		n_directed = pending_reqs.size();

		// random: mostly well-formed values, the rest edges and full-width noise
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: y = $urandom_range(FIRST_YEAR, LAST_YEAR);
					6, 7:             y = $urandom_range(0, 99);
					8:                y = ($urandom_range(0, 1) == 0) ? $urandom_range(1578, 1588)
						: $urandom_range(9994, 10004);
					default:          y = $urandom_range(0, 16383);
				endcase
				m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
				d = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
				h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
				mi = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
				ms = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 59999);
				add_date(y, m, d, h, mi, ms);
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: t = epoch_between(EARLIEST_MS, LATEST_MS);
					7: begin
						case ($urandom_range(0, 2))
							0:       t = EARLIEST_MS;
							1:       t = LATEST_MS;
							default: t = 0;
						endcase
						t = t + epoch_between(-2 * MS_DAY, 2 * MS_DAY);
					end
					default: t = longint'(any_epoch_ms());
				endcase
				add_epoch(t);
			end
		end
		// let the pipeline empty before the random part and again halfway through
		pending_reqs[n_directed].drain_before = 1'b1;
		pending_reqs[n_directed + RANDOM_REQS / 2].drain_before = 1'b1;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain requests, then results, then allow for a stray late strobe
		while (pending_reqs.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
